>>> rtl/core/suppressed_addback_histogrammer_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the suppressed add-back histogrammer core
// Each macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SUPPRESSED_ADDBACK_HISTOGRAMMER_CORE_DEFINES_SVH
`define SUPPRESSED_ADDBACK_HISTOGRAMMER_CORE_DEFINES_SVH

// same-cycle implication
`define SAH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SAH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/sah_pkg.sv
// ---------------------------------------------------------------------------
// sah_pkg
// Types and fixed constants of the suppressed add-back histogrammer.
// ---------------------------------------------------------------------------
package sah_pkg;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_DONE
  } state_t;

  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] REG_SUP_LOW  = 2'd0;
  localparam logic [1:0] REG_SUP_HIGH = 2'd1;
  localparam logic [1:0] REG_GAIN     = 2'd2;

  localparam int OVERFLOW_OFFSET = 1000;

  localparam int IN_TDATA_W  = 120;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_DATA_W  = 24;

  localparam logic [23:0] GAIN_RESET = 24'd65536;

endpackage

>>> rtl/core/suppressed_addback_histogrammer_core.sv
// ---------------------------------------------------------------------------
// suppressed_addback_histogrammer_core
// Suppression check, Q16 gain scaling and histogram increment or read-out.
//
//   channel | ports     | transfer
//   --------+-----------+-------------------------------------------
//   input   | in_*      | one accumulate or read request
//   output  | out_*     | one result per request
//   config  | cfg_*     | register write, index 0..2
//
// Each request steps through accept, RAM address, and RAM data and write-back,
// a read-modify-write through the single histogram RAM, before the next is taken.
// After reset a clearing pass writes zero to every RAM word, one a cycle, over
// 2**(clog2(POSITIONS)+clog2(2*CORES)+clog2(BINS)) words, 4194304 by default.
// in_tready stays low during the clear; config writes are taken throughout.
// A result waiting on out_tready does not block the next request until its
// own result is due.
// ---------------------------------------------------------------------------
`include "suppressed_addback_histogrammer_core_defines.svh"

module suppressed_addback_histogrammer_core #(
  parameter int POSITIONS = 16,
  parameter int CORES     = 4,
  parameter int BINS      = 32768
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // tdata: position[3:0], position_accepted[4], core_eligible_mask[8:5],
  //   core0_suppress[24:9], core1_suppress[40:25], core2_suppress[56:41],
  //   core3_suppress[72:57], addback_energy[96:73], addback_core[98:97],
  //   read_spectrum[101:99], read_bin[116:102], zero[119:117]
  input  logic [sah_pkg::IN_TDATA_W-1:0]     in_tdata,
  // tuser: opcode[0]
  input  logic                               in_tuser,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // tdata: count[31:0], spectrum[34:32], bin[49:35], suppressed[50],
  //   updated[51], zero[55:52]
  output logic [sah_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic                               cfg_we,
  input  logic [1:0]                         cfg_addr,
  input  logic [sah_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import sah_pkg::*;

  localparam int PW      = $clog2(POSITIONS);
  localparam int SPECTRA = 2 * CORES;
  localparam int SW      = $clog2(SPECTRA);
  localparam int BW      = $clog2(BINS);
  localparam int AW      = PW + SW + BW;
  localparam int DEPTH   = 1 << AW;

  localparam logic [6:0]  POS_LIM  = 7'(POSITIONS);
  localparam logic [3:0]  CORE_LIM = 4'(CORES);
  localparam logic [4:0]  SPEC_LIM = 5'(SPECTRA);
  localparam logic [31:0] BIN_LIM  = 32'(BINS);
  localparam logic [15:0] OVF_BIN  = 16'(BINS - OVERFLOW_OFFSET);
  localparam logic [3:0]  CORE_OFS = 4'(CORES);

  // configuration
  logic signed [15:0] sup_low_r;
  logic signed [15:0] sup_high_r;
  logic [23:0]        gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sup_low_r  <= '0;
      sup_high_r <= '0;
      gain_r     <= GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SUP_LOW:  sup_low_r  <= cfg_wdata[15:0];
        REG_SUP_HIGH: sup_high_r <= cfg_wdata[15:0];
        REG_GAIN:     gain_r     <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [3:0]         in_pos;
  logic               in_accepted;
  logic [3:0]         in_mask;
  logic signed [15:0] in_sup [4];
  logic signed [23:0] in_energy;
  logic [1:0]         in_core;
  logic [2:0]         in_rspec;
  logic [14:0]        in_rbin;

  assign in_pos      = in_tdata[3:0];
  assign in_accepted = in_tdata[4];
  assign in_mask     = in_tdata[8:5];
  assign in_sup[0]   = in_tdata[24:9];
  assign in_sup[1]   = in_tdata[40:25];
  assign in_sup[2]   = in_tdata[56:41];
  assign in_sup[3]   = in_tdata[72:57];
  assign in_energy   = in_tdata[96:73];
  assign in_core     = in_tdata[98:97];
  assign in_rspec    = in_tdata[101:99];
  assign in_rbin     = in_tdata[116:102];

  logic accept;
  logic supp_hit;
  logic acc_ok;
  logic rd_ok;
  logic signed [48:0] energy_ext;
  logic signed [48:0] gain_ext;
  logic signed [48:0] prod;

  assign accept = in_tvalid && in_tready;

  always_comb begin
    supp_hit = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (c < CORES && in_mask[c] && in_sup[c] >= sup_low_r && in_sup[c] <= sup_high_r) begin
        supp_hit = 1'b1;
      end
    end
  end

  assign acc_ok = (in_tuser == OP_ACCUM) && (in_pos != 4'd0) && ({3'b0, in_pos} < POS_LIM)
                  && in_accepted && ({2'b0, in_core} < CORE_LIM);
  assign rd_ok  = ({3'b0, in_pos} < POS_LIM) && ({2'b0, in_rspec} < SPEC_LIM)
                  && ({17'b0, in_rbin} < BIN_LIM);

  assign energy_ext = 49'(in_energy);
  assign gain_ext   = {25'b0, gain_r};
  assign prod       = energy_ext * gain_ext;

  // request registers
  logic               op_r;
  logic               acc_ok_r;
  logic               rd_ok_r;
  logic               supp_r;
  logic signed [48:0] prod_r;
  logic [3:0]         pos_r;
  logic [1:0]         core_r;
  logic [2:0]         rspec_r;
  logic [14:0]        rbin_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_tuser;
      acc_ok_r <= acc_ok;
      rd_ok_r  <= rd_ok;
      supp_r   <= supp_hit & acc_ok;
      prod_r   <= prod;
      pos_r    <= in_pos;
      core_r   <= in_core;
      rspec_r  <= in_rspec;
      rbin_r   <= in_rbin;
    end
  end

  // bin and spectrum, formed in the address cycle
  logic [31:0]   scaled;
  logic [15:0]   bin_nxt;
  logic [3:0]    spec_nxt;
  logic [15:0]   bin_r;
  logic [3:0]    spec_r;
  logic [AW-1:0] addr_nxt;
  logic [AW-1:0] addr_r;

  assign scaled = prod_r[47:16];

  always_comb begin
    if (op_r == OP_READ) begin
      spec_nxt = {1'b0, rspec_r};
      bin_nxt  = {1'b0, rbin_r};
    end else if (acc_ok_r) begin
      spec_nxt = {2'b0, core_r} + (supp_r ? CORE_OFS : 4'd0);
      if (prod_r[48] || scaled >= BIN_LIM) begin
        bin_nxt = OVF_BIN;
      end else begin
        bin_nxt = scaled[15:0];
      end
    end else begin
      spec_nxt = '0;
      bin_nxt  = '0;
    end
  end

  assign addr_nxt = {PW'(pos_r), SW'(spec_nxt), BW'(bin_nxt)};

  // state machine and RAM control
  state_t        state_r;
  state_t        state_nxt;
  logic [AW-1:0] clr_addr_r;
  logic [AW-1:0] clr_addr_nxt;
  logic          advance;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [31:0]   ram_wdata;
  logic          ram_re;
  logic [31:0]   ram_rdata;
  logic [31:0]   count_nxt;

  assign advance = (state_r == ST_DONE) && (!out_tvalid || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    in_tready    = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = ram_rdata + 32'd1;
    ram_re       = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        ram_re    = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (advance) begin
          ram_we    = acc_ok_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ADDR) begin
      addr_r <= addr_nxt;
      bin_r  <= bin_nxt;
      spec_r <= spec_nxt;
    end
  end

  sah_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_nxt),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (acc_ok_r) begin
      count_nxt = ram_rdata + 32'd1;
    end else if (op_r == OP_READ && rd_ok_r) begin
      count_nxt = ram_rdata;
    end else begin
      count_nxt = '0;
    end
  end

  // output register
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [31:0] out_count_r;
  logic [2:0]  out_spec_r;
  logic [14:0] out_bin_r;
  logic        out_supp_r;
  logic        out_upd_r;

  assign out_valid_nxt = advance ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_count_r <= count_nxt;
      out_spec_r  <= spec_r[2:0];
      out_bin_r   <= bin_r[14:0];
      out_supp_r  <= supp_r;
      out_upd_r   <= acc_ok_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0, out_upd_r, out_supp_r, out_bin_r, out_spec_r, out_count_r};

  `SAH_ASSERT_NEXT(a_accept_to_addr, accept, state_r == ST_ADDR,
    "accepted transfer did not start a RAM access")
  `SAH_ASSERT_NOW(a_write_phase, ram_we, state_r == ST_CLEAR || state_r == ST_DONE,
    "histogram RAM written outside clear or write-back")
  `SAH_ASSERT_NOW(a_result_origin, $rose(out_tvalid), $past(state_r) == ST_DONE,
    "result appeared without a completed request")
  `SAH_ASSERT_NOW(a_supp_needs_update, out_tvalid && out_tdata[50], out_tdata[51],
    "suppressed flag set on a result that did not update")

endmodule

>>> rtl/core/sah_ram.sv
// ---------------------------------------------------------------------------
// sah_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module sah_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
